// ===== rtl/fbr_pkg.sv =====
`default_nettype none

package fbr_pkg;

	// payload buffer geometry
	localparam int MAX_PAYLOAD = 31;
	localparam int PAY_W = $clog2(MAX_PAYLOAD + 1);   // holds a count up to MAX_PAYLOAD
	localparam int IDX_W = $clog2(MAX_PAYLOAD);       // addresses one buffer entry

	// repeat counter
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

	// byte queue between front and back (power of two)
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	// register map (word index = paddr[3:2])
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_HEAD = 2'd0;
	localparam logic [1:0] REG_TAIL = 2'd1;
	localparam logic [1:0] REG_NEED = 2'd2;

	// register reset values
	localparam logic [7:0] HEAD_RST = 8'h1A;
	localparam logic [7:0] TAIL_RST = 8'h0A;
	localparam logic [CNT_W-1:0] NEED_RST = 4'd3;

	// result event codes
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_STORED = 3'd1;
	localparam logic [2:0] EV_ENDED  = 3'd2;
	localparam logic [2:0] EV_SHOWN  = 3'd3;
	localparam logic [2:0] EV_ABORT  = 3'd4;

	typedef logic [PAY_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [7:0]       head;
		logic [7:0]       tail;
		logic [CNT_W-1:0] need;
	} cfg_t;

	// classified received byte
	typedef struct packed {
		logic [7:0] data;
		logic       is_head;
		logic       is_tail;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/fbr_ram.sv =====
`default_nettype none

module fbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/fbr_fifo.sv =====
`default_nettype none

module fbr_fifo import fbr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output item_t      pop_item
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	logic           push_ok;
	logic           pop_ok;

	assign full     = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign push_ok  = push && !full;
	assign pop_ok   = pop && !empty;
	assign pop_item = mem_q[rp_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wp_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) wp_q <= wp_q + 1'b1;
			if (pop_ok)  rp_q <= rp_q + 1'b1;
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbr_front.sv =====
`default_nettype none

module fbr_front import fbr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// byte input
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,
	// toward the queue
	output logic                   push,
	output item_t                  push_item,
	input  wire logic              q_full,
	output cfg_t                   cfg
);

	logic [7:0]       head_q;
	logic [7:0]       tail_q;
	logic [CNT_W-1:0] need_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RST;
			tail_q <= TAIL_RST;
			need_q <= NEED_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_HEAD: head_q <= pwdata[7:0];
				REG_TAIL: tail_q <= pwdata[7:0];
				REG_NEED: need_q <= pwdata[CNT_W-1:0];
				default:  ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_HEAD: prdata = {24'd0, head_q};
			REG_TAIL: prdata = {24'd0, tail_q};
			REG_NEED: prdata = {{(32-CNT_W){1'b0}}, need_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg = '{head: head_q, tail: tail_q, need: need_q};

	// classify each byte against the delimiters
	assign s_tready          = !q_full;
	assign push              = s_tvalid;
	assign push_item.data    = s_tdata;
	assign push_item.is_head = (s_tdata == head_q);
	assign push_item.is_tail = (s_tdata == tail_q);

endmodule

`default_nettype wire

// ===== rtl/fbr_back.sv =====
`default_nettype none

module fbr_back import fbr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	// from the queue
	input  wire logic        q_empty,
	input  wire item_t       q_item,
	output logic             pop,
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_CMP     = 5'b00010,
		S_RES     = 5'b00100,
		S_SHOW_RD = 5'b01000,
		S_SHOW_WR = 5'b10000
	} state_t;

	state_t           state_q;
	logic             in_frame_q;
	cnt_t             pc_q;
	cnt_t             sl_q;
	cnt_t             cl_q;
	logic [CNT_W-1:0] count_q;
	logic             cand_sel_q;   // 1: candidate lives in bank 1
	cnt_t             cmp_idx_q;
	logic             rd_pend_q;
	idx_t             show_idx_q;
	logic [2:0]       res_ev_q;

	// output register
	logic             out_valid_q;
	logic             out_lamp_q;
	logic [2:0]       out_ev_q;
	logic [7:0]       out_byte_q;
	logic [4:0]       out_idx_q;
	logic             out_sv_q;
	logic             out_last_q;

	logic             can_load;
	logic             fr_we;
	idx_t             raddr;
	logic [7:0]       rd0;
	logic [7:0]       rd1;
	logic [7:0]       cand_byte;
	logic             mism;
	logic             match;
	logic             show_now;
	cnt_t             cl_next;
	logic             show_end;

	logic             emit;
	logic             emit_lamp;
	logic [2:0]       emit_ev;
	logic [7:0]       emit_byte;
	logic [4:0]       emit_idx;
	logic             emit_sv;
	logic             emit_last;

	assign can_load = !out_valid_q || m_tready;
	assign pop      = (state_q == S_IDLE) && !q_empty && can_load;

	// payload byte goes into the bank that is not the candidate
	assign fr_we = pop && in_frame_q && !q_item.is_tail && (pc_q != cnt_t'(MAX_PAYLOAD));
	assign raddr = (state_q == S_CMP) ? cmp_idx_q[IDX_W-1:0] : show_idx_q;

	fbr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_bank0 (
		.clk   (clk),
		.we    (fr_we && cand_sel_q),
		.waddr (pc_q[IDX_W-1:0]),
		.wdata (q_item.data),
		.raddr (raddr),
		.rdata (rd0)
	);

	fbr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_bank1 (
		.clk   (clk),
		.we    (fr_we && !cand_sel_q),
		.waddr (pc_q[IDX_W-1:0]),
		.wdata (q_item.data),
		.raddr (raddr),
		.rdata (rd1)
	);

	assign cand_byte = cand_sel_q ? rd1 : rd0;

	// string compare, one entry per cycle, on read data registered behind the address
	assign mism  = (sl_q != cl_q) || (rd_pend_q && (rd0 != rd1));
	assign match = (sl_q == cl_q) &&
	               ((sl_q == '0) || (rd_pend_q && (rd0 == rd1) && (cmp_idx_q == sl_q)));

	always_comb begin
		if (mism) begin
			show_now = (cfg.need == CNT_W'(1));
			cl_next  = sl_q;
		end else begin
			show_now = (count_q != COUNT_MAX) && ((count_q + 1'b1) == cfg.need);
			cl_next  = cl_q;
		end
	end

	assign show_end = ((cnt_t'(show_idx_q) + 1'b1) == cl_q);

	// result selection
	always_comb begin
		emit      = 1'b0;
		emit_lamp = 1'b0;
		emit_ev   = EV_NONE;
		emit_byte = '0;
		emit_idx  = '0;
		emit_sv   = 1'b0;
		emit_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					if (!in_frame_q) begin
						emit      = 1'b1;
						emit_lamp = q_item.is_head;
					end else if (!q_item.is_tail) begin
						emit = 1'b1;
						if (pc_q != cnt_t'(MAX_PAYLOAD)) begin
							emit_lamp = 1'b1;
							emit_ev   = EV_STORED;
						end else begin
							emit_ev = EV_ABORT;
						end
					end
				end
			end
			S_RES: begin
				emit    = can_load;
				emit_ev = res_ev_q;
			end
			S_SHOW_WR: begin
				emit      = can_load;
				emit_ev   = EV_SHOWN;
				emit_byte = cand_byte;
				emit_idx  = 5'(show_idx_q);
				emit_sv   = 1'b1;
				emit_last = show_end;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_frame_q <= 1'b0;
			pc_q       <= '0;
			sl_q       <= '0;
			cl_q       <= '0;
			count_q    <= '0;
			cand_sel_q <= 1'b0;
			cmp_idx_q  <= '0;
			rd_pend_q  <= 1'b0;
			show_idx_q <= '0;
			res_ev_q   <= EV_ENDED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (!in_frame_q) begin
							if (q_item.is_head) begin
								in_frame_q <= 1'b1;
								pc_q       <= '0;
								sl_q       <= '0;
							end
						end else if (!q_item.is_tail) begin
							if (pc_q != cnt_t'(MAX_PAYLOAD)) begin
								pc_q <= pc_q + 1'b1;
								if ((q_item.data != 8'd0) && (sl_q == pc_q)) begin
									sl_q <= sl_q + 1'b1;
								end
							end else begin
								in_frame_q <= 1'b0;
							end
						end else begin
							in_frame_q <= 1'b0;
							cmp_idx_q  <= '0;
							rd_pend_q  <= 1'b0;
							state_q    <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (mism || match) begin
						if (mism) begin
							cand_sel_q <= !cand_sel_q;
							cl_q       <= sl_q;
							count_q    <= CNT_W'(1);
						end else if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						show_idx_q <= '0;
						if (show_now && (cl_next != '0)) begin
							state_q <= S_SHOW_RD;
						end else begin
							res_ev_q <= show_now ? EV_SHOWN : EV_ENDED;
							state_q  <= S_RES;
						end
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				S_RES: begin
					if (can_load) state_q <= S_IDLE;
				end
				S_SHOW_RD: begin
					state_q <= S_SHOW_WR;
				end
				S_SHOW_WR: begin
					if (can_load) begin
						if (show_end) begin
							state_q <= S_IDLE;
						end else begin
							show_idx_q <= show_idx_q + 1'b1;
							state_q    <= S_SHOW_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_lamp_q <= emit_lamp;
			out_ev_q   <= emit_ev;
			out_byte_q <= emit_byte;
			out_idx_q  <= emit_idx;
			out_sv_q   <= emit_sv;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_idx_q, out_byte_q, out_ev_q, out_lamp_q};
	assign m_tuser  = out_sv_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/framed_byte_receiver_with_repeat_filter.sv =====
// Framed byte receiver with repeat filter.
// Bytes enter on the s_ stream (s_tdata = rx_byte). Each byte is compared with
// the head and tail registers, queued, and handled by a sequencer. Inside a
// frame, payload bytes go to a 31-entry buffer; a frame is kept as a C string
// and compared with the held candidate. Enough identical frames in a row
// (repeats_needed) produce a display run of the candidate bytes.
// Results leave on the m_ stream, one per byte, or one per candidate byte on
// a show; m_tlast marks the final result of a byte.
// A byte's result passes the queue and then the output register before it is
// presented on m_tvalid; non-tail bytes go at one per cycle while the sequencer
// is idle and m_tready does not stall. A tail byte leaves the queue; the string
// compare then reads buffer entries only when both lengths agree and are nonzero;
// then the result is loaded, or each byte of a display run is read from the
// buffer, then loaded into the output register.
// A stalled m_tready holds the output register; the queue then fills and
// s_tready drops, so no byte is lost. Reset returns to idle with an empty
// candidate, a zero repeat count and the registers at their defaults.
// Registers (APB, byte address 4*i): head_byte, tail_byte, repeats_needed.
`default_nettype none

module framed_byte_receiver_with_repeat_filter import fbr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// APB register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// byte input
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
	// results
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [23:0]       m_tdata,   // [0] lamp_on, [3:1] event_res,
	                                          // [11:4] show_byte, [16:12] show_index
	output logic                   m_tuser,   // [0] show_valid
	output logic                   m_tlast    // last
);

	cfg_t  cfg;
	item_t push_item;
	item_t q_item;
	logic  push;
	logic  q_full;
	logic  q_empty;
	logic  pop;

	fbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full),
		.cfg       (cfg)
	);

	fbr_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_item  (q_item)
	);

	fbr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
	import fbr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;

	// one result transaction as seen on the m_ stream
	typedef struct packed {
		logic       lamp;
		logic [2:0] ev;
		logic [7:0] sbyte;
		logic [4:0] sidx;
		logic       svalid;
		logic       fin;
	} rx_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// block ports
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [7:0] rx_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;        // [0] lamp_on, [3:1] event_res,
	                                   // [11:4] show_byte, [16:12] show_index
	logic              m_tuser;        // [0] show_valid
	logic              m_tlast;

	framed_byte_receiver_with_repeat_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// receiver model state and its copy of the registers
	logic [7:0] cfg_head = HEAD_RST;
	logic [7:0] cfg_tail = TAIL_RST;
	logic [3:0] cfg_need = NEED_RST;
	logic       rx_open = 1'b0;
	logic [5:0] pay_cnt = '0;
	logic [5:0] str_len = '0;
	logic [5:0] cand_len = '0;
	logic [3:0] rep_cnt = '0;
	logic [7:0] frm_bytes [MAX_PAYLOAD];
	logic [7:0] cand_bytes [MAX_PAYLOAD];

	rx_result_t expected_results [$];
	logic [7:0] pending_bytes [$];
	logic [7:0] frame_buf [MAX_PAYLOAD+1];

	int  queued_count = 0;
	int  accepted_count = 0;
	int  result_count = 0;
	int  fail_count = 0;
	int  show_count = 0;
	int  abort_count = 0;
	int  saturated_count = 0;
	int  cycle_count = 0;
	int  src_gap = 0;
	int  sink_gap = 0;
	bit  no_idle = 1'b0;
	bit  byte_taken = 1'b0;
	rx_result_t oldest;

	// directed bytes at the reset register values (head 1A, tail 0A, three repeats)
	logic [7:0] directed_bytes [25] = '{
		8'h00, 8'hFF,                        // noise while idle
		8'h1A, 8'h0A, 8'h1A, 8'h0A,          // empty frames match the reset candidate
		8'h1A, 8'h0A,                        // third one shows the empty candidate
		8'h1A, 8'h1A, 8'h00, 8'h7F, 8'h0A,   // head and zero inside the payload
		8'h1A, 8'h1A, 8'h00, 8'h80, 8'h0A,   // same string, other bytes after zero
		8'h1A, 8'h1A, 8'h0A,                 // third match: one-byte show
		8'h1A, 8'h80, 8'h01, 8'h0A           // new candidate
	};

	// advance the receiver model by one byte and queue the results it causes
	function automatic void predict_rx_byte(input logic [7:0] b);
		rx_result_t r;
		logic       match;
		logic       show;
		r = '0;
		r.fin = 1'b1;
		if (!rx_open) begin
			// idle: only the head byte opens a frame
			if (b == cfg_head) begin
				rx_open = 1'b1;
				pay_cnt = '0;
				str_len = '0;
				r.lamp = 1'b1;
			end
			r.ev = EV_NONE;
			expected_results.push_back(r);
		end else if (b != cfg_tail) begin
			// payload byte or overflow abort
			if (pay_cnt < MAX_PAYLOAD) begin
				frm_bytes[pay_cnt] = b;
				if (b != 8'h00 && str_len == pay_cnt)
					str_len = str_len + 1'b1;
				pay_cnt = pay_cnt + 1'b1;
				r.lamp = 1'b1;
				r.ev = EV_STORED;
			end else begin
				rx_open = 1'b0;
				r.ev = EV_ABORT;
				abort_count++;
			end
			expected_results.push_back(r);
		end else begin
			// tail: compare as C strings with the candidate
			rx_open = 1'b0;
			match = (str_len == cand_len);
			for (int i = 0; i < MAX_PAYLOAD; i++)
				if (i < str_len && frm_bytes[i] != cand_bytes[i])
					match = 1'b0;
			if (match) begin
				if (rep_cnt < COUNT_MAX) begin
					rep_cnt = rep_cnt + 1'b1;
					show = (rep_cnt == cfg_need);
				end else begin
					show = 1'b0;
					saturated_count++;
				end
			end else begin
				for (int i = 0; i < MAX_PAYLOAD; i++)
					if (i < str_len)
						cand_bytes[i] = frm_bytes[i];
				cand_len = str_len;
				rep_cnt = 4'd1;
				show = (cfg_need == 4'd1);
			end
			if (!show) begin
				r.ev = EV_ENDED;
				expected_results.push_back(r);
			end else if (cand_len == 0) begin
				r.ev = EV_SHOWN;
				expected_results.push_back(r);
				show_count++;
			end else begin
				for (int i = 0; i < cand_len; i++) begin
					r.ev = EV_SHOWN;
					r.sbyte = cand_bytes[i];
					r.sidx = 5'(i);
					r.svalid = 1'b1;
					r.fin = (i == cand_len - 1);
					expected_results.push_back(r);
				end
				show_count++;
			end
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// any byte that does not close the frame
	function automatic logic [7:0] pick_payload();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == cfg_tail)
			b = 8'($urandom);
		return b;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		queued_count++;
	endtask

	// reps identical frames; bytes after a zero change between repeats
	task automatic queue_run(input int len, input int reps, input bit force_zero);
		int zpos;
		zpos = len;
		for (int i = 0; i < len; i++)
			frame_buf[i] = pick_payload();
		if (len > 0 && cfg_tail != 8'h00 && (force_zero || $urandom_range(0, 7) == 0)) begin
			zpos = $urandom_range(0, len - 1);
			frame_buf[zpos] = 8'h00;
		end
		for (int n = 0; n < reps; n++) begin
			queue_byte(cfg_head);
			for (int i = 0; i < len; i++) begin
				if (i > zpos)
					frame_buf[i] = pick_payload();
				queue_byte(frame_buf[i]);
			end
			queue_byte(cfg_tail);
		end
	endtask

	// head plus one byte more than the buffer holds
	task automatic queue_overflow();
		queue_byte(cfg_head);
		for (int i = 0; i <= MAX_PAYLOAD; i++)
			queue_byte(pick_payload());
	endtask

	task automatic wait_idle();
		while (!(accepted_count == queued_count && expected_results.size() == 0))
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HEAD: cfg_head = data[7:0];
			REG_TAIL: cfg_tail = data[7:0];
			REG_NEED: cfg_need = data[3:0];
			default: ;
		endcase
	endtask

	// registers change only once the block has drained
	task automatic configure(input logic [7:0] head, input logic [7:0] tail,
			input logic [3:0] need);
		wait_idle();
		apb_write(REG_HEAD, {24'h0, head});
		apb_write(REG_TAIL, {24'h0, tail});
		apb_write(REG_NEED, {28'h0, need});
	endtask

	// mostly well-formed repeat runs, with noise and broken frames mixed in
	task automatic random_traffic(input int budget);
		int start;
		int k;
		int len;
		int reps;
		start = queued_count;
		while (queued_count - start < budget) begin
			k = $urandom_range(0, 99);
			if (k < 55) begin
				if (cfg_need <= 3 && $urandom_range(0, 9) == 0)
					len = MAX_PAYLOAD;
				else if (cfg_need > 3)
					len = $urandom_range(0, 3);
				else
					len = $urandom_range(0, 5);
				if ($urandom_range(0, 4) == 0)
					reps = $urandom_range(1, 3);
				else
					reps = $urandom_range(1, cfg_need + 1);
				queue_run(len, reps, 1'b0);
			end else if (k < 70) begin
				queue_run($urandom_range(1, 8), 1, 1'b1);
			end else if (k < 80) begin
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom));
			end else if (k < 88) begin
				queue_overflow();
			end else begin
				// frame left open; the next head lands in its payload
				queue_byte(cfg_head);
				repeat ($urandom_range(1, 4))
					queue_byte(pick_payload());
			end
		end
	endtask

	// reset and stimulus
	initial begin
		logic [7:0] h;
		logic [7:0] t;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_bytes[i])
			queue_byte(directed_bytes[i]);
		queue_overflow();
		random_traffic(25);

		configure(8'h00, 8'hFF, 4'd1);
		queue_run(MAX_PAYLOAD, 2, 1'b0);
		random_traffic(25);

		configure(8'hFF, 8'h00, 4'd15);
		queue_run(1, 15, 1'b0);
		random_traffic(20);

		h = 8'($urandom);
		t = 8'($urandom);
		while (t == h)
			t = 8'($urandom);
		configure(h, t, 4'd2);
		queue_run(0, 17, 1'b0);
		random_traffic(20);

		// head equal to tail, no idling from here on
		h = 8'($urandom);
		configure(h, h, 4'($urandom_range(1, 15)));
		no_idle = 1'b1;
		random_traffic(30);

		wait_idle();
		repeat (40) @(posedge clk);
		$display("Sent %0d bytes, checked %0d results over five register settings",
			accepted_count, result_count);
		$display("Shows: %0d, overflow aborts: %0d, matches at saturated count: %0d",
			show_count, abort_count, saturated_count);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// byte side: note each transaction and feed it to the model
	always @(posedge clk) begin
		byte_taken = arst_n && s_tvalid && s_tready;
		if (byte_taken) begin
			predict_rx_byte(s_tdata);
			accepted_count++;
		end
	end

	// byte driver with random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				s_tdata <= pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				if (!no_idle && $urandom_range(0, 9) == 0)
					src_gap = $urandom_range(1, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!no_idle && $urandom_range(0, 11) == 0)
					sink_gap = $urandom_range(1, 18);
			end
		end
	end

	// result monitor: compare against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with none expected: m_tdata 0x%0h", m_tdata);
				fail_count++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("lamp_on", oldest.lamp, m_tdata[0]);
				check_field("event_res", oldest.ev, m_tdata[3:1]);
				check_field("show_byte", oldest.sbyte, m_tdata[11:4]);
				check_field("show_index", oldest.sidx, m_tdata[16:12]);
				check_field("tdata padding", 0, m_tdata[23:17]);
				check_field("show_valid", oldest.svalid, m_tuser);
				check_field("last", oldest.fin, m_tlast);
				result_count++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
